// ===== rtl/atdt_pkg.sv =====
// Shared constants and tables for the tilt and double-tap unit.
// No dependencies.
`default_nettype none
package atdt_pkg;
    localparam int CordicIterations = 16;
    localparam int AtanLen = 24;

    localparam logic [1:0] REG_TAP_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_TAP_WINDOW    = 2'd1;

    localparam logic [15:0] TapThresholdReset = 16'd24576;
    localparam logic [7:0]  TapWindowReset    = 8'd30;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [21:0] atan_lookup(input logic [4:0] i);
        logic [21:0] r;
        case (i)
            5'd0: r = 22'd2949120;  5'd1: r = 22'd1740967;  5'd2: r = 22'd919879;
            5'd3: r = 22'd466945;   5'd4: r = 22'd234379;   5'd5: r = 22'd117304;
            5'd6: r = 22'd58666;    5'd7: r = 22'd29335;    5'd8: r = 22'd14668;
            5'd9: r = 22'd7334;     5'd10: r = 22'd3667;    5'd11: r = 22'd1833;
            5'd12: r = 22'd917;     5'd13: r = 22'd458;     5'd14: r = 22'd229;
            5'd15: r = 22'd115;     5'd16: r = 22'd57;      5'd17: r = 22'd29;
            5'd18: r = 22'd14;      5'd19: r = 22'd7;       5'd20: r = 22'd4;
            5'd21: r = 22'd2;       5'd22: r = 22'd1;       default: r = 22'd0;
        endcase
        return r;
    endfunction

    // calibration matrix, 2^-30 g per milli-g
    function automatic logic signed [21:0] cal_coef(input logic [1:0] row,
                                                    input logic [1:0] col);
        logic signed [21:0] r;
        case ({row, col})
            4'b0000: r = -22'sd1077787;
            4'b0001: r =  22'sd25005;
            4'b0010: r = -22'sd10656;
            4'b0100: r = -22'sd14286;
            4'b0101: r =  22'sd1094592;
            4'b0110: r =  22'sd1167;
            4'b1000: r = -22'sd14661;
            4'b1001: r = -22'sd4066;
            4'b1010: r =  22'sd1077024;
            default: r = '0;
        endcase
        return r;
    endfunction

    // calibration offsets, 2^-30 g
    function automatic logic signed [39:0] cal_offset(input logic [1:0] row);
        logic signed [39:0] r;
        case (row)
            2'd0:    r =  40'sd17593244;
            2'd1:    r = -40'sd8379722;
            2'd2:    r = -40'sd39436009;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/accel_tilt_and_double_tap_unit.sv =====
// Tilt angles and double-tap detection, top level with sequencer.
// Depends on atdt_pkg, atdt_isqrt, atdt_cordic.
// Steps per beat: idle, calibration, squares, three square-root passes, two CORDIC passes, output.
// s_tready is high only in idle; a finished result waits in S_DONE until the output register frees.
// aresetn (synchronous, active low) resets tap state, sequencer and config; datapath is not reset.
`default_nettype none
module accel_tilt_and_double_tap_unit #(
    parameter int CORDIC_ITERATIONS = atdt_pkg::CordicIterations
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // pitch_angle[14:0], roll_angle[28:15], double_tap[29]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    localparam logic [2:0] S_IDLE = 3'd0, S_CAL = 3'd1, S_SQ = 3'd2, S_SQRT_GO = 3'd3,
                           S_SQRT_WAIT = 3'd4, S_CORD_GO = 3'd5, S_CORD_WAIT = 3'd6,
                           S_DONE = 3'd7;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [15:0] thr_reg;
    logic [7:0]  win_reg;

    // tap state
    logic [7:0] wcnt_reg, wcnt_next, pcnt_reg, pcnt_next;
    logic       inpk_reg, inpk_next, tap_flag;

    // sample and datapath
    logic signed [15:0] raw_reg [3];
    logic signed [15:0] g_reg   [3];
    logic [31:0]        sq_reg  [3];
    logic [15:0]        rt_reg  [3];
    logic signed [39:0] acc_reg, sum;
    logic signed [37:0] prod_reg;
    logic signed [21:0] ma;
    logic signed [15:0] mb;
    logic signed [23:0] rnd;
    logic signed [15:0] g_sat;
    logic [1:0]         cr_reg, cc_reg, pr_reg, pc_reg;
    logic               iss_reg, pv_reg;
    logic [1:0]         ph_reg;
    logic signed [13:0] pitch_c_reg;
    // roll rides here until the beat is built
    logic signed [13:0] roll_reg;

    // shared units
    logic        sq_start, sq_done, cd_start, cd_done;
    logic [31:0] sq_in;
    logic [15:0] sq_root;
    logic signed [15:0] cd_num;
    logic [15:0]        cd_den;
    logic signed [13:0] cd_angle;
    logic signed [15:0] pitch_a, pitch_b;

    atdt_isqrt u_isqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .radicand(sq_in),
        .done(sq_done), .root(sq_root)
    );

    atdt_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cd_start), .num(cd_num), .den(cd_den),
        .done(cd_done), .angle(cd_angle)
    );

    assign s_tready = (state_reg == S_IDLE);

    // multiplier operands: calibration terms or squares
    always_comb begin
        if (state_reg == S_SQ) begin
            ma = 22'(g_reg[cr_reg]);
            mb = g_reg[cr_reg];
        end else begin
            ma = atdt_pkg::cal_coef(cr_reg, cc_reg);
            mb = raw_reg[cc_reg];
        end
    end

    // accumulate, round half up to Q2.14, saturate
    always_comb begin
        sum = ((pc_reg == 2'd0) ? atdt_pkg::cal_offset(pr_reg) : acc_reg) + 40'(prod_reg);
        rnd = 24'((sum + 40'sd32768) >>> 16);
        if (rnd > 24'sd32767)       g_sat = 16'sd32767;
        else if (rnd < -24'sd32768) g_sat = -16'sd32768;
        else                        g_sat = rnd[15:0];
    end

    // radicands: x^2+z^2, y^2+z^2, x^2+y^2+z^2
    always_comb begin
        case (ph_reg)
            2'd0:    sq_in = sq_reg[0] + sq_reg[2];
            2'd1:    sq_in = sq_reg[1] + sq_reg[2];
            default: sq_in = sq_reg[0] + sq_reg[1] + sq_reg[2];
        endcase
    end

    assign sq_start = (state_reg == S_SQRT_GO);
    assign cd_start = (state_reg == S_CORD_GO);
    assign cd_num   = (ph_reg == 2'd0) ? g_reg[1] : g_reg[0];
    assign cd_den   = (ph_reg == 2'd0) ? rt_reg[0] : rt_reg[1];

    // pitch fold for z below zero, then wrap into 0..360
    always_comb begin
        pitch_a = g_reg[2][15] ? (16'sd11520 - 16'(pitch_c_reg)) : 16'(pitch_c_reg);
        pitch_b = pitch_a[15] ? (pitch_a + 16'sd23040) : pitch_a;
    end

    // tap detector, evaluated at end of sample
    always_comb begin
        wcnt_next = wcnt_reg;
        pcnt_next = pcnt_reg;
        inpk_next = inpk_reg;
        tap_flag  = 1'b0;
        if (inpk_reg) begin
            if (rt_reg[2] < thr_reg) begin
                if (pcnt_reg != 8'd255) pcnt_next = pcnt_reg + 8'd1;
                inpk_next = 1'b0;
                if (pcnt_next == 8'd2) tap_flag = 1'b1;
            end
        end else if (rt_reg[2] > thr_reg) begin
            inpk_next = 1'b1;
        end
        if (!tap_flag) begin
            wcnt_next = wcnt_reg + 8'd1;
            if (wcnt_next == win_reg) begin
                wcnt_next = '0;
                pcnt_next = '0;
                inpk_next = 1'b0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_CAL;
            S_CAL:       if (pv_reg && pr_reg == 2'd2 && pc_reg == 2'd2) state_next = S_SQ;
            S_SQ:        if (pv_reg && pr_reg == 2'd2) state_next = S_SQRT_GO;
            S_SQRT_GO:   state_next = S_SQRT_WAIT;
            S_SQRT_WAIT: if (sq_done) state_next = (ph_reg == 2'd2) ? S_CORD_GO : S_SQRT_GO;
            S_CORD_GO:   state_next = S_CORD_WAIT;
            S_CORD_WAIT: if (cd_done) state_next = (ph_reg == 2'd1) ? S_DONE : S_CORD_GO;
            S_DONE:      if (!m_tvalid || m_tready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            thr_reg   <= atdt_pkg::TapThresholdReset;
            win_reg   <= atdt_pkg::TapWindowReset;
            wcnt_reg  <= '0;
            pcnt_reg  <= '0;
            inpk_reg  <= 1'b0;
            m_tvalid  <= 1'b0;
            iss_reg   <= 1'b0;
            pv_reg    <= 1'b0;
            cr_reg    <= '0;
            cc_reg    <= '0;
            ph_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we && cfg_addr == atdt_pkg::REG_TAP_THRESHOLD) thr_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == atdt_pkg::REG_TAP_WINDOW)    win_reg <= cfg_wdata[7:0];
            if (state_reg == S_DONE && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
            else if (m_tvalid && m_tready)                      m_tvalid <= 1'b0;
            pv_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    cr_reg  <= '0;
                    cc_reg  <= '0;
                    ph_reg  <= '0;
                    iss_reg <= s_tvalid;
                end
                S_CAL: begin
                    if (iss_reg) begin
                        pv_reg <= 1'b1;
                        if (cc_reg == 2'd2) begin
                            cc_reg <= '0;
                            if (cr_reg == 2'd2) begin
                                cr_reg  <= '0;
                                iss_reg <= 1'b0;
                            end else begin
                                cr_reg <= cr_reg + 2'd1;
                            end
                        end else begin
                            cc_reg <= cc_reg + 2'd1;
                        end
                    end
                    if (pv_reg && pr_reg == 2'd2 && pc_reg == 2'd2) iss_reg <= 1'b1;
                end
                S_SQ: begin
                    if (iss_reg) begin
                        pv_reg <= 1'b1;
                        if (cr_reg == 2'd2) iss_reg <= 1'b0;
                        else                cr_reg  <= cr_reg + 2'd1;
                    end
                end
                S_SQRT_WAIT: begin
                    if (sq_done) ph_reg <= (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
                end
                S_CORD_WAIT: begin
                    if (cd_done) ph_reg <= ph_reg + 2'd1;
                end
                S_DONE: begin
                    if (!m_tvalid || m_tready) begin
                        wcnt_reg <= wcnt_next;
                        pcnt_reg <= pcnt_next;
                        inpk_reg <= inpk_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            raw_reg[0] <= s_tdata[15:0];
            raw_reg[1] <= s_tdata[31:16];
            raw_reg[2] <= s_tdata[47:32];
        end
        if ((state_reg == S_CAL || state_reg == S_SQ) && iss_reg) begin
            prod_reg <= ma * mb;
            pr_reg   <= cr_reg;
            pc_reg   <= cc_reg;
        end
        if (state_reg == S_CAL && pv_reg) begin
            acc_reg <= sum;
            if (pc_reg == 2'd2) g_reg[pr_reg] <= g_sat;
        end
        if (state_reg == S_SQ && pv_reg) sq_reg[pr_reg] <= prod_reg[31:0];
        if (state_reg == S_SQRT_WAIT && sq_done) rt_reg[ph_reg] <= sq_root;
        if (state_reg == S_CORD_WAIT && cd_done && ph_reg == 2'd0) pitch_c_reg <= cd_angle;
        if (state_reg == S_CORD_WAIT && cd_done && ph_reg == 2'd1) roll_reg <= cd_angle;
        if (state_reg == S_DONE && (!m_tvalid || m_tready)) begin
            m_tdata <= {2'b00, tap_flag, roll_reg, pitch_b[14:0]};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/atdt_isqrt.sv =====
// Iterative floor square root, two radicand bits per cycle.
// Depends on nothing.
`default_nettype none
module atdt_isqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] radicand,
    output logic             done,
    output logic [15:0]      root
);
    logic [31:0] val_reg, val_next;
    logic [17:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [17:0] rem_sh, trial;

    always_comb begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[15:0], val_reg[31:30]};
        trial     = {root_reg, 2'b01};
        if (start) begin
            val_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[29:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[14:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

// ===== rtl/atdt_cordic.sv =====
// Vectoring CORDIC, one rotation per cycle; angle in 1/64 degree.
// Depends on atdt_pkg (arctangent table).
`default_nettype none
module atdt_cordic #(
    parameter int ITERATIONS = atdt_pkg::CordicIterations
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [15:0] num,
    input  wire logic [15:0]        den,
    output logic                    done,
    output logic signed [13:0]      angle
);
    localparam int CntW = $clog2(ITERATIONS + 1);
    localparam int Last = ITERATIONS - 1;

    logic signed [27:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic signed [25:0] acc_reg, acc_next, acc_rnd;
    logic [CntW-1:0]    cnt_reg, cnt_next;
    logic               busy_reg, busy_next, done_reg, done_next;
    logic               zero_reg, zero_next;
    logic signed [15:0] rnd;
    logic signed [13:0] ang_reg, ang_next;
    logic [4:0]         idx;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        ang_next  = ang_reg;
        idx       = 5'(cnt_reg);
        xs        = x_reg >>> idx;
        ys        = y_reg >>> idx;
        acc_rnd   = acc_reg + 26'sd512;
        rnd       = acc_rnd[25:10];
        if (start) begin
            x_next    = {4'b0, den, 8'b0};
            y_next    = {{4{num[15]}}, num, 8'b0};
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
            zero_next = (num == 16'sd0);
        end else if (busy_reg) begin
            if (!y_reg[27]) begin
                x_next   = x_reg + ys;
                y_next   = y_reg - xs;
                acc_next = acc_reg + $signed({4'b0, atdt_pkg::atan_lookup(idx)});
            end else begin
                x_next   = x_reg - ys;
                y_next   = y_reg + xs;
                acc_next = acc_reg - $signed({4'b0, atdt_pkg::atan_lookup(idx)});
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CntW'(Last)) begin
                busy_next = 1'b0;
            end
        end else if (cnt_reg == CntW'(ITERATIONS)) begin
            // finish: round, clamp; a zero numerator gives zero
            cnt_next  = '0;
            done_next = 1'b1;
            if (zero_reg)                 ang_next = '0;
            else if (rnd > 16'sd5760)     ang_next = 14'sd5760;
            else if (rnd < -16'sd5760)    ang_next = -14'sd5760;
            else                          ang_next = rnd[13:0];
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
        zero_reg <= zero_next;
        ang_reg  <= ang_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done  = done_reg;
    assign angle = ang_reg;
endmodule
`default_nettype wire

// ===== tb/tb_accel_tilt_and_double_tap_unit.sv =====
// Testbench for accel_tilt_and_double_tap_unit: calibrated tilt angles and double-tap flag.
// Depends on atdt_pkg and the RTL top; predicts each result in-line and checks every m_ beat.
`default_nettype none
module tb_accel_tilt_and_double_tap_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        tap;
        logic [13:0] roll;
        logic [14:0] pitch;
    } tilt_res_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;

    accel_tilt_and_double_tap_unit dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [15:0] thr_q;
    logic [7:0]  win_q;
    logic [7:0]  win_cnt, pk_cnt;
    logic        in_pk;
    tilt_res_t   tilt_q[$];
    int          errors = 0;
    int          snd_idle = 0, rcv_idle = 0;   // percent
    int          hold_cycles = 0;
    int          quiet = 0;
    localparam int WatchdogLimit = 20000;

    // floor shift for signed 64-bit
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res = 0, bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint tilt_angle(longint num, longint den);
        longint x = den * 256, y = num * 256, acc = 0, xs, ys, r;
        if (num == 0) return 0;
        for (int i = 0; i < atdt_pkg::CordicIterations && i < atdt_pkg::AtanLen; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc += longint'(atdt_pkg::atan_lookup(5'(i)));
            end else begin
                x = x - ys; y = y + xs; acc -= longint'(atdt_pkg::atan_lookup(5'(i)));
            end
        end
        r = fshift(acc + 512, 10);
        if (r > 5760) r = 5760;
        if (r < -5760) r = -5760;
        return r;
    endfunction

    // works out one result and advances the tap detector
    task automatic predict_tilt(input logic [47:0] d);
        longint raw[3], g[3], s, pitch, roll, mag;
        tilt_res_t r;
        raw[0] = longint'($signed(d[15:0]));
        raw[1] = longint'($signed(d[31:16]));
        raw[2] = longint'($signed(d[47:32]));
        for (int k = 0; k < 3; k++) begin
            s = longint'(atdt_pkg::cal_offset(2'(k)));
            for (int c = 0; c < 3; c++)
                s += longint'(atdt_pkg::cal_coef(2'(k), 2'(c))) * raw[c];
            s = fshift(s + 32768, 16);
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
            g[k] = s;
        end
        pitch = tilt_angle(g[1], int_sqrt(g[0]*g[0] + g[2]*g[2]));
        if (g[2] < 0) pitch = 11520 - pitch;
        if (pitch < 0) pitch += 23040;
        roll = tilt_angle(g[0], int_sqrt(g[1]*g[1] + g[2]*g[2]));
        r.pitch = pitch[14:0];
        r.roll = roll[13:0];
        r.tap = 1'b0;
        mag = int_sqrt(g[0]*g[0] + g[1]*g[1] + g[2]*g[2]);
        if (in_pk) begin
            if (mag < longint'(thr_q)) begin
                if (pk_cnt < 8'd255) pk_cnt++;
                in_pk = 1'b0;
                // second peak: flag, window count held this step
                if (pk_cnt == 8'd2) r.tap = 1'b1;
            end
        end else if (mag > longint'(thr_q)) begin
            in_pk = 1'b1;
        end
        if (!r.tap) begin
            win_cnt = win_cnt + 8'd1;
            if (win_cnt == win_q) begin
                win_cnt = '0; pk_cnt = '0; in_pk = 1'b0;
            end
        end
        tilt_q.push_back(r);
    endtask

    // one input beat, predicted on acceptance; tvalid stays up for a following beat
    task automatic send_sample(input logic [15:0] ax, ay, az);
        while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {az, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tilt({az, ay, ax});
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tilt_q.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] v);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == atdt_pkg::REG_TAP_THRESHOLD) thr_q = v;
        else if (idx == atdt_pkg::REG_TAP_WINDOW) win_q = v[7:0];
        @(posedge aclk);
    endtask

    // receiver: random stall plus an optional long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    // result checker
    always @(posedge aclk) begin
        tilt_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[29:0];
            if (tilt_q.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, m_tdata);
                errors++;
            end else begin
                want = tilt_q.pop_front();
                if (got.pitch !== want.pitch) begin
                    $display("%0t: pitch exp %0d got %0d", $time, want.pitch, got.pitch);
                    errors++;
                end
                if (got.roll !== want.roll) begin
                    $display("%0t: roll exp %0d got %0d", $time,
                             $signed(want.roll), $signed(got.roll));
                    errors++;
                end
                if (got.tap !== want.tap) begin
                    $display("%0t: tap exp %0b got %0b", $time, want.tap, got.tap);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || hold_cycles > 0)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WatchdogLimit) begin
            $display("tb_accel_tilt_and_double_tap_unit NOT OK");
            $finish;
        end
    end

    // full-scale corners, zero, and the pitch fold and wrap cases
    task automatic test_directed();
        logic [15:0] ext[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        for (int i = 0; i < 4; i++) send_sample(ext[i], ext[(i+1)%4], ext[(i+2)%4]);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(-16'sd17, 16'd8, 16'd1000);      // near zero x and y after offset
        send_sample(16'd0, 16'd0, -16'sd1000);       // z negative: pitch mirror
        send_sample(16'd0, -16'sd700, -16'sd700);    // y and z negative: pitch mirror, no wrap
        send_sample(16'd1000, 16'd0, 16'd0);
        send_sample(-16'sd1000, 16'd0, 16'd0);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        drain_results();
    endtask

    // bursts of taps: high peaks separated by rest samples
    task automatic tap_burst(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 3)
                send_sample(16'($urandom_range(600) - 300), 16'($urandom_range(600) - 300),
                            16'($urandom_range(4000) + 1800));
            else if ($urandom_range(9) < 8)
                send_sample(16'($urandom_range(200) - 100), 16'($urandom_range(200) - 100),
                            16'($urandom_range(200) + 900));
            else
                send_sample(16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    task automatic test_random(input int n, input int si, input int ri);
        snd_idle = si; rcv_idle = ri;
        tap_burst(n);
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_cycles = 1500;
        snd_idle = 0;
        tap_burst(12);
        drain_results();
        // pause until every result is back, then continue
        tap_burst(8);
        drain_results();
    endtask

    task automatic test_config();
        write_reg(atdt_pkg::REG_TAP_THRESHOLD, 16'd0);
        write_reg(atdt_pkg::REG_TAP_WINDOW, 16'd1);
        test_random(30, 0, 0);
        write_reg(atdt_pkg::REG_TAP_THRESHOLD, 16'hFFFF);
        write_reg(atdt_pkg::REG_TAP_WINDOW, 16'd255);
        test_random(30, 10, 10);
        write_reg(atdt_pkg::REG_TAP_WINDOW, 16'd0);      // wraps after 256
        write_reg(atdt_pkg::REG_TAP_THRESHOLD, 16'd16384);
        test_random(40, 0, 0);
        write_reg(atdt_pkg::REG_TAP_THRESHOLD, 16'd20000);
        write_reg(atdt_pkg::REG_TAP_WINDOW, 16'd12);
    endtask

    initial begin
        thr_q = atdt_pkg::TapThresholdReset; win_q = atdt_pkg::TapWindowReset;
        win_cnt = '0; pk_cnt = '0; in_pk = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config();
        test_random(200, 23, 55);
        test_random(200, 55, 23);
        test_random(150, 0, 0);
        test_backpressure();
        drain_results();
        if (errors == 0 && tilt_q.size() == 0)
            $display("tb_accel_tilt_and_double_tap_unit OK");
        else
            $display("tb_accel_tilt_and_double_tap_unit NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
